// ===== rtl/core/mmh_pkg.sv =====
// ----------------------------------------------------------------------------
// mmh_pkg
// types and constants shared by the merging max heap
// ----------------------------------------------------------------------------
`default_nettype none
package mmh_pkg;
    localparam int unsigned CAPACITY_DEF = 64;
    localparam int unsigned ID_W = 32;
    localparam int unsigned CNT_W = 24;
    localparam int unsigned HELD_W = 7;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   user_id;
        logic [CNT_W-1:0]  post_count;
    } mmh_req_t;

    typedef struct packed {
        logic [ID_W-1:0]   top_user;
        logic [CNT_W-1:0]  top_count;
        logic              was_empty;
        logic              dropped_full;
        logic [HELD_W-1:0] entries_held;
    } mmh_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CHK,
        ST_MERGE,
        ST_RISE_RD,
        ST_RISE_CMP,
        ST_POP_RD,
        ST_POP_MV,
        ST_SINK_RD,
        ST_SINK_CMP,
        ST_SINK_SEL,
        ST_DONE
    } mmh_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/merging_max_heap.sv =====
// ----------------------------------------------------------------------------
// merging_max_heap
// binary max-heap of (id, count) entries with merge on push and pop of max
// ----------------------------------------------------------------------------
// channel | direction | payload
// req     | in        | mmh_req_t  (req_valid / req_stall)
// rsp     | out       | mmh_rsp_t  (rsp_valid / rsp_stall)
//
// one request at a time; a push searches for the id linearly over the single
// memory read port and then bubbles up level by level, a pop sifts down level
// by level; the single memory read port sets the pace of both.
// reset clears the state, the entry count and the output valid only; store contents are never read unwritten.
// the result waits in an output register; the next request is taken when the
// result is transferred or while it is being transferred.
// ----------------------------------------------------------------------------
`default_nettype none
module merging_max_heap #(
    parameter int unsigned CAPACITY = mmh_pkg::CAPACITY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire mmh_pkg::mmh_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output mmh_pkg::mmh_rsp_t      rsp
);
    import mmh_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned NW = $clog2(CAPACITY + 1);
    localparam logic [NW-1:0] CAP_N = NW'(CAPACITY);

    logic [CNT_W-1:0] cnt_mem [CAPACITY];
    logic [ID_W-1:0]  id_mem  [CAPACITY];

    mmh_state_t state_reg, state_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [AW-1:0]    i_reg, i_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [ID_W-1:0]  uid_reg, uid_next;
    logic [CNT_W-1:0] amt_reg, amt_next;
    logic [CNT_W-1:0] ci_reg, ci_next;
    logic [ID_W-1:0]  ii_reg, ii_next;
    logic [CNT_W-1:0] cl_reg, cl_next;
    logic [ID_W-1:0]  il_reg, il_next;
    logic             rsp_valid_reg, rsp_valid_next;
    mmh_rsp_t         rsp_reg, rsp_next;

    // one read port
    logic [AW-1:0]    rd_addr;
    logic [CNT_W-1:0] rd_cnt;
    logic [ID_W-1:0]  rd_id;
    // one write port
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [CNT_W-1:0] wr_cnt;
    logic [ID_W-1:0]  wr_id;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
            id_mem[wr_addr]  <= wr_id;
        end
        rd_cnt <= cnt_mem[rd_addr];
        rd_id  <= id_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        uid_reg <= uid_next;
        amt_reg <= amt_next;
        ci_reg  <= ci_next;
        ii_reg  <= ii_next;
        cl_reg  <= cl_next;
        il_reg  <= il_next;
        rsp_reg <= rsp_next;
    end

    logic             accept;
    logic             out_free;
    logic [CNT_W:0]   sum;
    logic [AW:0]      lchild;
    logic [AW:0]      rchild;
    logic [NW-1:0]    n_dec;
    logic             found;
    logic             take_right;
    logic             sink_swap;

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = !(state_reg == ST_IDLE && out_free);
    assign accept     = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign sum        = {1'b0, rd_cnt} + {1'b0, amt_reg};
    assign lchild     = {i_reg, 1'b1};
    assign rchild     = lchild + 1'b1;
    assign n_dec      = n_reg - 1'b1;
    assign found      = n_reg != '0 && cl_reg[0];
    // pick right, if the right child exists, unless left is strictly larger
    assign take_right = rchild < (AW+1)'(n_reg) && !(cl_reg > rd_cnt);
    assign sink_swap  = take_right ? (ci_reg < rd_cnt) : (ci_reg < cl_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_POP)
                        state_next = (n_reg == '0) ? ST_DONE : ST_POP_RD;
                    else
                        state_next = (n_reg == '0) ? ST_MERGE : ST_SRCH;
                end
            end
            ST_SRCH:     state_next = ST_SRCH_CHK;
            ST_SRCH_CHK:
            begin
                if (rd_id == uid_reg)
                    state_next = ST_MERGE;
                else if (NW'(i_reg) + 1'b1 >= n_reg)
                    state_next = ST_MERGE;
                else
                    state_next = ST_SRCH_CHK;
            end
            ST_MERGE:    state_next = (found || n_reg < CAP_N) ? ST_RISE_RD : ST_DONE;
            ST_RISE_RD:  state_next = (i_reg == '0) ? ST_DONE : ST_RISE_CMP;
            ST_RISE_CMP: state_next = (rd_cnt < ci_reg) ? ST_RISE_RD : ST_DONE;
            ST_POP_RD:   state_next = ST_POP_MV;
            ST_POP_MV:   state_next = ST_SINK_RD;
            ST_SINK_RD:  state_next = (lchild < (AW+1)'(n_reg)) ? ST_SINK_CMP : ST_DONE;
            ST_SINK_CMP: state_next = ST_SINK_SEL;
            ST_SINK_SEL: state_next = sink_swap ? ST_SINK_RD : ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        uid_next       = uid_reg;
        amt_next       = amt_reg;
        ci_next        = ci_reg;
        ii_next        = ii_reg;
        cl_next        = cl_reg;
        il_next        = il_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_addr        = i_reg;
        wr_en          = 1'b0;
        wr_addr        = i_reg;
        wr_cnt         = ci_reg;
        wr_id          = ii_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    uid_next = req.user_id;
                    amt_next = req.post_count;
                    i_next   = '0;
                    j_next   = '0;
                    rsp_next = '0;
                    rd_addr  = '0;
                    if (req.req_type == REQ_POP && n_reg == '0)
                        rsp_next.was_empty = 1'b1;
                end
            end
            ST_SRCH:
            begin
                rd_addr = '0;
            end
            ST_SRCH_CHK:
            begin
                // i holds the slot under compare, i+1 the next read; j takes i on a match
                if (rd_id == uid_reg)
                begin
                    j_next = i_reg;
                    i_next = i_reg;
                    ci_next = (sum[CNT_W]) ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
                    ii_next = uid_reg;
                    cl_next = CNT_W'(1'b1);
                end
                else
                begin
                    i_next  = i_reg + 1'b1;
                    rd_addr = i_reg + 1'b1;
                    cl_next = '0;
                end
            end
            ST_MERGE:
            begin
                if (n_reg != '0 && cl_reg[0] && state_reg == ST_MERGE)
                begin
                    rd_addr = i_reg;
                end
                else if (n_reg >= CAP_N)
                begin
                    rsp_next.dropped_full = 1'b1;
                end
                else
                begin
                    i_next  = AW'(n_reg);
                    ci_next = amt_reg;
                    ii_next = uid_reg;
                    n_next  = n_reg + 1'b1;
                end
                rd_addr = AW'((AW'(i_next) - 1'b1) >> 1);
            end
            ST_RISE_RD:
            begin
                // parent read issued in the previous cycle; write cur at i
                wr_en   = !rsp_reg.dropped_full;
                wr_addr = i_reg;
                wr_cnt  = ci_reg;
                wr_id   = ii_reg;
                j_next  = AW'((i_reg - 1'b1) >> 1);
                rd_addr = AW'((i_reg - 1'b1) >> 1);
            end
            ST_RISE_CMP:
            begin
                if (rd_cnt < ci_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = i_reg;
                    wr_cnt  = rd_cnt;
                    wr_id   = rd_id;
                    i_next  = j_reg;
                    rd_addr = AW'((j_reg - 1'b1) >> 1);
                end
            end
            ST_POP_RD:
            begin
                rsp_next.top_user  = rd_id;
                rsp_next.top_count = rd_cnt;
                rd_addr = AW'(n_dec);
                n_next  = n_dec;
            end
            ST_POP_MV:
            begin
                // last entry moves to the root and sinks
                ci_next = rd_cnt;
                ii_next = rd_id;
                i_next  = '0;
            end
            ST_SINK_RD:
            begin
                rd_addr = AW'(lchild);
                wr_en   = 1'b1;
                wr_addr = i_reg;
            end
            ST_SINK_CMP:
            begin
                cl_next = rd_cnt;
                il_next = rd_id;
                rd_addr = AW'(rchild);
            end
            ST_SINK_SEL:
            begin
                if (sink_swap)
                begin
                    wr_en   = 1'b1;
                    wr_addr = i_reg;
                    if (take_right)
                    begin
                        wr_cnt = rd_cnt;
                        wr_id  = rd_id;
                        i_next = AW'(rchild);
                    end
                    else
                    begin
                        wr_cnt = cl_reg;
                        wr_id  = il_reg;
                        i_next = AW'(lchild);
                    end
                end
            end
            ST_DONE:
            begin
                rsp_next.entries_held = HELD_W'(n_reg);
                rsp_valid_next        = 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
